@@ src/zigzag_scan_reorder_top_defines.svh @@
// Assertion macros for the zigzag scan reorder block.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef ZIGZAG_SCAN_REORDER_TOP_DEFINES_SVH
`define ZIGZAG_SCAN_REORDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ZSR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("zigzag scan reorder check failed");

// Next-cycle implication, disabled during reset.
`define ZSR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("zigzag scan reorder check failed");

`endif

@@ src/zsr_pkg.sv @@
// Shared types and constants for the zigzag scan reorder block.
// No dependencies.
package zsr_pkg;

   localparam int MAX_SIDE_DEFAULT = 8;
   localparam int DATA_W           = 32;
   localparam int CSR_W            = 4;
   localparam logic [CSR_W-1:0] N_SIZE_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // control from the top level into the scan walker
   typedef struct packed {
      logic start;
      logic step;
   } walk_ctl_type;

endpackage

@@ src/zsr_scan_walk.sv @@
// Zigzag position walker: steps row/column along anti-diagonals.
// Depends on zsr_pkg.
module zsr_scan_walk #(
   parameter int MAX_SIDE = zsr_pkg::MAX_SIDE_DEFAULT,
   parameter int SW       = $clog2(MAX_SIDE + 1),
   parameter int AW       = (MAX_SIDE * MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  zsr_pkg::walk_ctl_type ctl,
   input  logic [SW-1:0]        side,
   output logic [AW-1:0]        addr,
   output logic                 last
);
   import zsr_pkg::*;

   localparam int RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int CW = 2 * SW;

   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] col_ff, col_in;
   logic          up_ff, up_in;
   logic [RW-1:0] nm1;
   logic [CW-1:0] lin;

   assign nm1  = RW'(side - SW'(1));
   assign lin  = CW'(row_ff) * CW'(side) + CW'(col_ff);
   assign addr = AW'(lin);
   assign last = (row_ff == nm1) && (col_ff == nm1);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      up_in  = up_ff;
      if (ctl.start) begin
         row_in = '0;
         col_in = '0;
         up_in  = 1'b1;
      end else if (ctl.step) begin
         if (up_ff) begin
            // toward top-right; turn at top edge or right edge
            if (row_ff == '0 || col_ff == nm1) begin
               if (col_ff != nm1) col_in = col_ff + RW'(1);
               else               row_in = row_ff + RW'(1);
               up_in = 1'b0;
            end else begin
               row_in = row_ff - RW'(1);
               col_in = col_ff + RW'(1);
            end
         end else begin
            // toward bottom-left; turn at left edge or bottom edge
            if (col_ff == '0 || row_ff == nm1) begin
               if (row_ff != nm1) row_in = row_ff + RW'(1);
               else               col_in = col_ff + RW'(1);
               up_in = 1'b1;
            end else begin
               row_in = row_ff + RW'(1);
               col_in = col_ff - RW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         up_ff  <= 1'b1;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         up_ff  <= up_in;
      end
   end

endmodule

@@ src/zigzag_scan_reorder_top.sv @@
// Zigzag scan reorder, top level: element store, load counter, output queue.
// Depends on zsr_pkg and zsr_scan_walk.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_element
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_out_element, rsp_last
//  csr     | in        | csr_wr_en              | csr_wr_data (n_size)
//
// Loading accepts an element whenever req_valid is high and req_stall is low.
// On the n*n-th element the block scans: one store read per cycle while the
// output queue has room, for n*n results; req_stall is high for the whole scan.
// The single store read port sets the scan rate. A 2-beat output queue keeps
// reads going while rsp_stall is high; reads pause when it would overflow.
// Synchronous reset clears counter, state and queue; the store is not cleared.
module zigzag_scan_reorder_top #(
   parameter int MAX_SIDE = zsr_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [zsr_pkg::DATA_W-1:0]  req_element,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [zsr_pkg::DATA_W-1:0]  rsp_out_element,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [zsr_pkg::CSR_W-1:0]          csr_wr_data
);
   import zsr_pkg::*;

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int CW    = 2 * SW;

   logic [CSR_W-1:0]  n_size_ff;
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SW-1:0]     side;
   logic [CW-1:0]     total;
   logic [CW-1:0]     count_inc;
   logic              load_acc;
   logic              scan_start;

   logic [DATA_W-1:0] store [DEPTH];
   logic [DATA_W-1:0] rd_q_ff;
   logic              rd_pend_ff;
   logic              rd_last_ff;

   walk_ctl_type      walk_ctl;
   logic [AW-1:0]     walk_addr;
   logic              walk_last;
   logic              issue;

   logic [DATA_W-1:0] q_data_ff [2];
   logic [1:0]        q_last_ff;
   logic              q_wr_ff, q_rd_ff;
   logic [1:0]        q_cnt_ff;
   logic [1:0]        q_occ;
   logic              pop;

   // side length in use: zero acts as one, saturate at the built maximum
   always_comb begin
      if (n_size_ff == '0)
         side = SW'(1);
      else if (32'(n_size_ff) > MAX_SIDE)
         side = SW'(MAX_SIDE);
      else
         side = SW'(n_size_ff);
   end

   assign total      = CW'(side) * CW'(side);
   assign count_inc  = count_ff + CW'(1);
   assign req_stall  = (state_ff != ST_LOAD);
   assign load_acc   = req_valid && !req_stall;
   assign scan_start = load_acc && (count_inc >= total);

   // queue space counts the read in flight; one read per cycle while the queue has room
   assign pop    = rsp_valid && !rsp_stall;
   assign q_occ  = q_cnt_ff + {1'b0, rd_pend_ff} - {1'b0, pop};
   assign issue  = (state_ff == ST_SCAN) && (q_occ < 2'd2);

   assign walk_ctl.start = scan_start;
   assign walk_ctl.step  = issue;

   zsr_scan_walk #(
      .MAX_SIDE (MAX_SIDE),
      .SW       (SW),
      .AW       (AW)
   ) u_walk (
      .clock (clock),
      .reset (reset),
      .ctl   (walk_ctl),
      .side  (side),
      .addr  (walk_addr),
      .last  (walk_last)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (load_acc) begin
               if (scan_start) begin
                  count_in = '0;
                  state_in = ST_SCAN;
               end else begin
                  count_in = count_inc;
               end
            end
         end
         ST_SCAN: begin
            if (issue && walk_last) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_size_ff <= N_SIZE_RESET;
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
      end else begin
         if (csr_wr_en) n_size_ff <= csr_wr_data;
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Store: writes only while loading, reads only while scanning, so the
   // element that triggers a scan is written before the first read.
   always_ff @(posedge clock) begin
      if (load_acc) store[count_ff[AW-1:0]] <= req_element;
      if (issue)    rd_q_ff <= store[walk_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) rd_last_ff <= walk_last;
   end

   // two-beat output queue
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= '0;
      end else begin
         if (rd_pend_ff) q_wr_ff <= ~q_wr_ff;
         if (pop)        q_rd_ff <= ~q_rd_ff;
         q_cnt_ff <= q_cnt_ff + {1'b0, rd_pend_ff} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         q_data_ff[q_wr_ff] <= rd_q_ff;
         q_last_ff[q_wr_ff] <= rd_last_ff;
      end
   end

   assign rsp_valid       = (q_cnt_ff != '0);
   assign rsp_out_element = q_data_ff[q_rd_ff];
   assign rsp_last        = q_last_ff[q_rd_ff];

endmodule

@@ src/zsr_checker.sv @@
// Port-level checker for the zigzag scan reorder block, bound to the top level.
// Depends on zigzag_scan_reorder_top_defines.svh.
`include "zigzag_scan_reorder_top_defines.svh"

module zsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_element,
   input logic        rsp_last
);

   // stalled result beat holds
   `ZSR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_element) && $stable(rsp_last))

   // nothing to deliver right out of reset
   `ZSR_ASSERT_NOW(a_rsp_idle_after_reset, $past(reset), !rsp_valid)

   // input stalls only after taking the element that completes a matrix
   `ZSR_ASSERT_NOW(a_stall_after_load, $rose(req_stall), $past(req_valid))

   // handshake outputs are always known once out of reset
   `ZSR_ASSERT_NOW(a_handshake_known, 1'b1,
      !$isunknown(rsp_valid) && !$isunknown(req_stall))

endmodule

bind zigzag_scan_reorder_top zsr_checker u_zsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_element (rsp_out_element),
   .rsp_last        (rsp_last)
);
